### src/kaiser_bessel_weight_macros.svh
// assertion macros for the kaiser-bessel weight block
// included by the top module, which checks its own pipeline; no dependencies
`ifndef KAISER_BESSEL_WEIGHT_MACROS_SVH
`define KAISER_BESSEL_WEIGHT_MACROS_SVH
`ifndef SYNTH
`define KBW_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kbw assertion failed");
`define KBW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kbw assertion failed");
`else
`define KBW_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define KBW_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### src/kbw_pkg.sv
// shared types, constants and the square root step of the kaiser-bessel weight block
// no dependencies
package kbw_pkg;

   localparam logic [62:0] WeightMax = {63{1'b1}};
   localparam logic [62:0] TermOne   = 63'(1) << 20;
   localparam logic [13:0] HalfQ14   = 14'd8192;

   // side data that travels with a word through the series stages
   typedef struct packed {
      logic        outside;
      logic        sat;
      logic [62:0] sum;
      logic [61:0] usq;
   } kbw_lane_type;

   // remainder and partial root of the bit-pair square root
   typedef struct packed {
      logic [32:0] v;
      logic [32:0] r;
   } kbw_root_type;

   function automatic kbw_root_type kbw_sqrt_step(kbw_root_type cur, logic [32:0] bitv);
      kbw_root_type nxt;
      logic [33:0]  trial;
      trial = {1'b0, cur.r} + {1'b0, bitv};
      nxt   = cur;
      if ({1'b0, cur.v} >= trial) begin
         nxt.v = 33'({1'b0, cur.v} - trial);
         nxt.r = (cur.r >> 1) + bitv;
      end else begin
         nxt.r = cur.r >> 1;
      end
      return nxt;
   endfunction

endpackage

### src/kaiser_bessel_weight.sv
// Kaiser-Bessel gridding weight: one offset word in, one weight word out.
// Channels: req_ carries a signed Q2.14 offset, rsp_ returns the weight (Q43.20)
// and an outside-support flag; csr_we/csr_wdata set the shape beta (Q5.10).
// Write beta only while no word is in flight.
// From acceptance to rsp_tvalid a word passes 9 front stages (magnitude,
// 1-4x^2, a five-stage bit-pair square root, u and u^2) and 64 series term
// units of 12 stages each, one term of the power series per unit.
// Throughput is one word per clock while the output is not stalled by rsp_tready.
// The whole pipeline moves on one enable: when rsp_tvalid is high and rsp_tready
// low, every stage holds, req_tready drops, and the output word stays put.
// Reset clears all valid bits and sets beta to zero; data registers keep their
// contents but are marked empty. Offsets beyond one half give weight zero and
// outside_support set; zero beta or the support edge give weight 1.0.
// Depends on kbw_pkg, kbw_term and kaiser_bessel_weight_macros.svh.
`include "kaiser_bessel_weight_macros.svh"
module kaiser_bessel_weight (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] offset
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [62:0] weight, [63] outside_support
   input  logic        csr_we,
   input  logic [14:0] csr_wdata
);

   localparam int NFront = 9;

   logic        advance;
   logic [14:0] beta_ff;
   logic        fv_ff [0:NFront-1];
   logic        fo_ff [0:NFront-1];
   logic [15:0] mag_ff, mag_in;
   logic [32:0] v_ff, v_in;
   logic [27:0] sq;
   kbw_pkg::kbw_root_type root_ff [0:4];
   logic [30:0] u_ff;
   logic [61:0] usq_ff;
   logic                  chain_valid [0:64];
   kbw_pkg::kbw_lane_type chain_lane  [0:64];
   logic [62:0]           chain_term  [0:64];
   logic [62:0] weight;

   assign advance    = !chain_valid[64] || rsp_tready;
   assign req_tready = advance;

   // beta register
   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff <= '0;
      end else if (csr_we) begin
         beta_ff <= csr_wdata;
      end
   end

   // front valid bits and support flag
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NFront; s++) fv_ff[s] <= 1'b0;
      end else if (advance) begin
         fv_ff[0] <= req_tvalid;
         for (int s = 1; s < NFront; s++) fv_ff[s] <= fv_ff[s-1];
      end
   end

   assign mag_in = req_tdata[15] ? 16'(-req_tdata) : req_tdata;

   always_ff @(posedge clock) begin
      if (advance) begin
         fo_ff[0] <= mag_in > 16'(kbw_pkg::HalfQ14);
         for (int s = 1; s < NFront; s++) fo_ff[s] <= fo_ff[s-1];
      end
   end

   // magnitude, then 16 * (1 - 4x^2) in Q5.28
   assign sq   = 28'(mag_ff[13:0]) * 28'(mag_ff[13:0]);
   assign v_in = {29'(29'd1 << 28) - {sq[26:0], 2'b00}, 4'b0000};

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_ff <= mag_in;
         v_ff   <= v_in;
      end
   end

   // square root, four bit pairs per stage, one in the last stage
   for (genvar j = 0; j < 5; j++) begin : g_root
      kbw_pkg::kbw_root_type src;
      kbw_pkg::kbw_root_type st;

      if (j == 0) begin : g_first
         assign src = '{v: v_ff, r: '0};
      end else begin : g_next
         assign src = root_ff[j-1];
      end

      always_comb begin
         st = src;
         for (int i = 4 * j; i < 4 * j + 4; i++) begin
            if (i <= 16) st = kbw_pkg::kbw_sqrt_step(st, 33'(1) << (2 * (16 - i)));
         end
      end

      always_ff @(posedge clock) begin
         if (advance) root_ff[j] <= st;
      end
   end

   // u = root * beta, then u squared
   always_ff @(posedge clock) begin
      if (advance) begin
         u_ff   <= 31'(32'(root_ff[4].r[16:0]) * 32'(beta_ff));
         usq_ff <= 62'(u_ff) * 62'(u_ff);
      end
   end

   // series: one term unit per power of u^2/4
   assign chain_valid[0] = fv_ff[NFront-1];
   assign chain_lane[0]  = '{outside: fo_ff[NFront-1], sat: 1'b0,
                             sum: kbw_pkg::TermOne, usq: usq_ff};
   assign chain_term[0]  = kbw_pkg::TermOne;

   for (genvar k = 1; k <= 64; k++) begin : g_term
      kbw_term #(.K(k)) u_term (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chain_valid[k-1]),
         .in_lane   (chain_lane[k-1]),
         .in_term   (chain_term[k-1]),
         .out_valid (chain_valid[k]),
         .out_lane  (chain_lane[k]),
         .out_term  (chain_term[k])
      );
   end

   // result word
   assign weight     = chain_lane[64].outside ? '0 : chain_lane[64].sum;
   assign rsp_tvalid = chain_valid[64];
   assign rsp_tdata  = {chain_lane[64].outside, weight};

   // inside the support the root of a value up to 2^32 never passes 2^16
   `KBW_ASSERT_IMPL(a_root_bound, clock, reset, fv_ff[6] && !fo_ff[6], root_ff[4].r <= 33'd65536)
   // a weight inside the support is never below 1.0
   `KBW_ASSERT_IMPL(a_weight_floor, clock, reset, rsp_tvalid && !rsp_tdata[63],
                    weight >= kbw_pkg::TermOne)
   // the series has died out by its last term
   `KBW_ASSERT_IMPL(a_last_term_zero, clock, reset, rsp_tvalid, chain_term[64] == '0)
   // beta below 32 keeps the sum clear of saturation
   `KBW_ASSERT_IMPL(a_no_saturation, clock, reset, rsp_tvalid, !chain_lane[64].sat)
   // a stalled pipeline keeps its squared argument
   `KBW_ASSERT_NEXT(a_stall_holds, clock, reset, !advance, $stable(usq_ff))

endmodule

### src/kbw_term.sv
// one series term of the bessel sum: term * u^2 / (4 k^2), added to the running sum
// depends on kbw_pkg; twelve register stages, held by the shared advance enable
module kbw_term #(
   parameter int K = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  kbw_pkg::kbw_lane_type in_lane,
   input  logic [62:0]          in_term,
   output logic                 out_valid,
   output kbw_pkg::kbw_lane_type out_lane,
   output logic [62:0]          out_term
);

   localparam int D  = K * K;
   localparam int Lg = $clog2(D);
   localparam int Sh = 29 + Lg;
   localparam longint unsigned RecipBig =
      ((64'd1 << (29 + Lg)) + 64'(D) - 64'd1) / 64'(D);
   localparam logic [30:0] RecipMul = 31'(RecipBig);
   localparam int NStage = 12;

   logic                  valid_ff [0:NStage-1];
   kbw_pkg::kbw_lane_type lane_ff  [0:NStage-1];
   logic [62:0] ll_ff, lh_ff, ll_in, lh_in;
   logic [61:0] hl_ff, hh_ff, hl_in, hh_in;
   logic [124:0] prod_in;
   logic [79:0] n_ff [1:9];
   logic [79:0] q_ff [1:10];
   logic [28:0] cur_ff [0:3];
   logic [15:0] qd_ff [0:3];
   logic [12:0] rem_ff [0:3];
   logic [62:0] term_ff, term_in;
   kbw_pkg::kbw_lane_type lane_in;
   logic [63:0] sumx;
   logic        big;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NStage; s++) valid_ff[s] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < NStage; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   // side data passes unchanged up to the final add
   always_ff @(posedge clock) begin
      if (advance) begin
         lane_ff[0] <= in_lane;
         for (int s = 1; s < NStage - 1; s++) lane_ff[s] <= lane_ff[s-1];
         lane_ff[NStage-1] <= lane_in;
      end
   end

   // partial products of term times u squared
   assign ll_in = 63'(in_term[31:0])  * 63'(in_lane.usq[30:0]);
   assign lh_in = 63'(in_term[31:0])  * 63'(in_lane.usq[61:31]);
   assign hl_in = 62'(in_term[62:32]) * 62'(in_lane.usq[30:0]);
   assign hh_in = 62'(in_term[62:32]) * 62'(in_lane.usq[61:31]);

   // full product, scaled down by 2^54
   assign prod_in = 125'(ll_ff) + (125'(lh_ff) << 31) + (125'(hl_ff) << 32)
                  + (125'(hh_ff) << 63);

   always_ff @(posedge clock) begin
      if (advance) begin
         ll_ff   <= ll_in;
         lh_ff   <= lh_in;
         hl_ff   <= hl_in;
         hh_ff   <= hh_in;
         n_ff[1] <= 80'(prod_in[124:54]);
         q_ff[1] <= '0;
      end
   end

   // long division by k^2, sixteen bits a step, top chunk first
   for (genvar c = 0; c < 5; c++) begin : g_chunk
      localparam int Ia = 2 + 2 * c;
      logic [12:0] rem_src;
      logic [28:0] cur_in;
      logic [59:0] recip_prod;
      logic [15:0] qd_in;

      if (c == 0) begin : g_first
         assign rem_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[c-1];
      end

      assign cur_in     = {rem_src, n_ff[Ia-1][79-16*c -: 16]};
      assign recip_prod = 60'(cur_in) * 60'(RecipMul);
      assign qd_in      = 16'(recip_prod >> Sh);

      // quotient digit by reciprocal
      always_ff @(posedge clock) begin
         if (advance) begin
            q_ff[Ia]  <= q_ff[Ia-1] | (80'(qd_in) << (64 - 16 * c));
         end
      end

      if (c < 4) begin : g_rem
         // remainder for the next digit
         always_ff @(posedge clock) begin
            if (advance) begin
               cur_ff[c]   <= cur_in;
               qd_ff[c]    <= qd_in;
               n_ff[Ia]    <= n_ff[Ia-1];
               rem_ff[c]   <= 13'(cur_ff[c] - 29'(qd_ff[c]) * 29'(D));
               n_ff[Ia+1]  <= n_ff[Ia];
               q_ff[Ia+1]  <= q_ff[Ia];
            end
         end
      end
   end

   // saturating accumulate of the new term
   assign big  = |q_ff[10][79:63];
   assign sumx = {1'b0, lane_ff[10].sum} + {1'b0, q_ff[10][62:0]};

   always_comb begin
      lane_in     = lane_ff[10];
      lane_in.sat = lane_ff[10].sat | big | sumx[63];
      lane_in.sum = lane_in.sat ? kbw_pkg::WeightMax : sumx[62:0];
      term_in     = big ? kbw_pkg::WeightMax : q_ff[10][62:0];
   end

   always_ff @(posedge clock) begin
      if (advance) term_ff <= term_in;
   end

   assign out_valid = valid_ff[NStage-1];
   assign out_lane  = lane_ff[NStage-1];
   assign out_term  = term_ff;

endmodule
